/* design/nds_pkg.sv */
package nds_pkg;

    localparam int unsigned DEF_MAX_DEPTH = 32;
    localparam int unsigned DEF_MAX_LINE  = 1024;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_QUOTE_CHAR  = 3'd0;
    localparam logic [2:0] REG_MASK_CHAR_A = 3'd1;
    localparam logic [2:0] REG_MASK_CHAR_B = 3'd2;
    localparam logic [2:0] REG_MASK_CHAR_C = 3'd3;
    localparam logic [2:0] REG_MASK_CHAR_D = 3'd4;
    localparam logic [2:0] REG_MASK_COUNT  = 3'd5;
    localparam logic [2:0] REG_STRICT_MODE = 3'd6;

    localparam logic [7:0] RST_QUOTE_CHAR  = 8'd34;
    localparam logic [7:0] RST_MASK_CHAR_A = 8'd32;
    localparam logic [7:0] RST_MASK_CHAR_B = 8'd0;
    localparam logic [7:0] RST_MASK_CHAR_C = 8'd0;
    localparam logic [7:0] RST_MASK_CHAR_D = 8'd0;
    localparam logic [2:0] RST_MASK_COUNT  = 3'd1;
    localparam logic       RST_STRICT_MODE = 1'b1;

    localparam logic [7:0] CHAR_APOSTROPHE = 8'h27;
    localparam logic [7:0] CHAR_LPAREN     = 8'h28;
    localparam logic [7:0] CHAR_RPAREN     = 8'h29;
    localparam logic [7:0] CHAR_LSQUARE    = 8'h5b;
    localparam logic [7:0] CHAR_RSQUARE    = 8'h5d;

    typedef enum logic [1:0] {
        MISMATCH_NONE  = 2'd0,
        MISMATCH_PAREN = 2'd1,
        MISMATCH_SQUARE = 2'd2
    } mismatch_t;

    typedef struct packed {
        logic [7:0] character;
        logic       first;
    } nds_in_t;

    typedef struct packed {
        logic       hit;
        logic [9:0] position;
        logic [1:0] mismatch;
        logic       depth_overflow;
    } nds_out_t;

endpackage

/* design/nested_delimiter_scanner.sv */
// Delimiter scanner: one character per item, one item per cycle sustained while out_stall
// is low. Each item is captured in an input register and then evaluated against the scan
// state (nesting depth, bracket kinds, quote state, square hiding, position) by a short
// compare and increment path that loads the result register and the next state together.
// Each item passes the input register, then the result register. The input register keeps
// taking items while a result waits, until both stages are full. Set first on the opening
// character of each line. Program the APB registers only while no item is in flight.
module nested_delimiter_scanner #(
    parameter int unsigned MAX_DEPTH = nds_pkg::DEF_MAX_DEPTH,
    parameter int unsigned MAX_LINE  = nds_pkg::DEF_MAX_LINE
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  nds_pkg::nds_in_t             in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output nds_pkg::nds_out_t            out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nds_pkg::ADDR_W-1:0]   paddr,
    input  logic [nds_pkg::DATA_W-1:0]   pwdata,
    output logic [nds_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import nds_pkg::*;

    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned KW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int unsigned PW = $clog2(MAX_LINE);
    localparam logic [DW-1:0] DEPTH_LIMIT = DW'(MAX_DEPTH);
    localparam logic [PW-1:0] POS_LIMIT   = PW'(MAX_LINE - 1);

    // configuration
    logic [7:0] quote_char_reg;
    logic [7:0] mask_char_a_reg;
    logic [7:0] mask_char_b_reg;
    logic [7:0] mask_char_c_reg;
    logic [7:0] mask_char_d_reg;
    logic [2:0] mask_count_reg;
    logic       strict_mode_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_char_reg  <= RST_QUOTE_CHAR;
            mask_char_a_reg <= RST_MASK_CHAR_A;
            mask_char_b_reg <= RST_MASK_CHAR_B;
            mask_char_c_reg <= RST_MASK_CHAR_C;
            mask_char_d_reg <= RST_MASK_CHAR_D;
            mask_count_reg  <= RST_MASK_COUNT;
            strict_mode_reg <= RST_STRICT_MODE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_QUOTE_CHAR:  quote_char_reg  <= pwdata[7:0];
                REG_MASK_CHAR_A: mask_char_a_reg <= pwdata[7:0];
                REG_MASK_CHAR_B: mask_char_b_reg <= pwdata[7:0];
                REG_MASK_CHAR_C: mask_char_c_reg <= pwdata[7:0];
                REG_MASK_CHAR_D: mask_char_d_reg <= pwdata[7:0];
                REG_MASK_COUNT:  mask_count_reg  <= pwdata[2:0];
                REG_STRICT_MODE: strict_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (cfg_index)
            REG_QUOTE_CHAR:  prdata[7:0] = quote_char_reg;
            REG_MASK_CHAR_A: prdata[7:0] = mask_char_a_reg;
            REG_MASK_CHAR_B: prdata[7:0] = mask_char_b_reg;
            REG_MASK_CHAR_C: prdata[7:0] = mask_char_c_reg;
            REG_MASK_CHAR_D: prdata[7:0] = mask_char_d_reg;
            REG_MASK_COUNT:  prdata[2:0] = mask_count_reg;
            REG_STRICT_MODE: prdata[0]   = strict_mode_reg;
            default:         prdata      = '0;
        endcase
    end

    // pipeline control
    logic     in_valid_reg;
    nds_in_t  in_item_reg;
    logic     out_valid_reg;
    nds_out_t out_item_reg;
    logic     advance;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // scan state
    logic [DW-1:0]        nest_depth_reg, nest_depth_next;
    logic [MAX_DEPTH-1:0] bracket_kinds_reg, bracket_kinds_next;
    logic [1:0]           quote_state_reg, quote_state_next;
    logic                 square_open_reg, square_open_next;
    logic [PW-1:0]        char_index_reg, char_index_next;
    nds_out_t             result;

    logic [DW-1:0]        cur_depth;
    logic [MAX_DEPTH-1:0] cur_kinds;
    logic [1:0]           cur_quote;
    logic                 cur_square;
    logic [PW-1:0]        cur_index;
    logic [7:0]           ch;
    logic                 is_open, is_close, consumed, was_square, is_delim;
    logic [DW-1:0]        depth_dec;

    always_comb
    begin
        ch         = in_item_reg.character;
        cur_depth  = in_item_reg.first ? '0 : nest_depth_reg;
        cur_kinds  = in_item_reg.first ? '0 : bracket_kinds_reg;
        cur_quote  = in_item_reg.first ? '0 : quote_state_reg;
        cur_square = in_item_reg.first ? 1'b0 : square_open_reg;
        cur_index  = in_item_reg.first ? '0 : char_index_reg;

        nest_depth_next    = cur_depth;
        bracket_kinds_next = cur_kinds;
        quote_state_next   = cur_quote;
        square_open_next   = cur_square;
        char_index_next    = (cur_index < POS_LIMIT) ? cur_index + 1'b1 : cur_index;

        depth_dec  = cur_depth - 1'b1;
        was_square = cur_kinds[depth_dec[KW-1:0]];
        consumed   = 1'b0;

        result                = '0;
        result.position       = 10'(cur_index);
        result.mismatch       = MISMATCH_NONE;

        if (cur_quote == 2'b00)
        begin
            if (strict_mode_reg)
            begin
                is_open  = (ch == CHAR_LPAREN) || (ch == CHAR_LSQUARE);
                is_close = (ch == CHAR_RPAREN) || (ch == CHAR_RSQUARE);
                if (is_open)
                begin
                    if (cur_depth >= DEPTH_LIMIT)
                        result.depth_overflow = 1'b1;
                    else
                    begin
                        bracket_kinds_next[cur_depth[KW-1:0]] = (ch == CHAR_LSQUARE);
                        nest_depth_next = cur_depth + 1'b1;
                    end
                end
                else if (is_close && cur_depth != '0)
                begin
                    nest_depth_next = depth_dec;
                    consumed        = 1'b1;
                    if (ch == CHAR_RPAREN && was_square)
                        result.mismatch = MISMATCH_PAREN;
                    if (ch == CHAR_RSQUARE && !was_square)
                        result.mismatch = MISMATCH_SQUARE;
                end
            end
            else
            begin
                is_open  = 1'b0;
                is_close = 1'b0;
                if (cur_square)
                begin
                    if (ch == CHAR_RSQUARE)
                        square_open_next = 1'b0;
                end
                else if (ch == CHAR_LPAREN)
                begin
                    if (cur_depth >= DEPTH_LIMIT)
                        result.depth_overflow = 1'b1;
                    else
                    begin
                        bracket_kinds_next[cur_depth[KW-1:0]] = 1'b0;
                        nest_depth_next = cur_depth + 1'b1;
                    end
                end
                else if (ch == CHAR_RPAREN && cur_depth != '0)
                begin
                    nest_depth_next = depth_dec;
                    consumed        = 1'b1;
                end
                if (!consumed && nest_depth_next == '0 && ch == CHAR_LSQUARE)
                    square_open_next = 1'b1;
            end
        end
        else
        begin
            is_open  = 1'b0;
            is_close = 1'b0;
        end

        is_delim = ((mask_count_reg >= 3'd1) && (ch == mask_char_a_reg)) ||
                   ((mask_count_reg >= 3'd2) && (ch == mask_char_b_reg)) ||
                   ((mask_count_reg >= 3'd3) && (ch == mask_char_c_reg)) ||
                   ((mask_count_reg >= 3'd4) && (ch == mask_char_d_reg));

        if (!consumed)
        begin
            // the programmable quote wins when it equals the apostrophe
            if (ch == quote_char_reg)
            begin
                if (!cur_quote[1])
                    quote_state_next[0] = !cur_quote[0];
            end
            else if (ch == CHAR_APOSTROPHE)
            begin
                if (!cur_quote[0])
                    quote_state_next[1] = !cur_quote[1];
            end
            result.hit = (nest_depth_next == '0) && (quote_state_next == 2'b00) &&
                         (strict_mode_reg || !square_open_next) && is_delim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            nest_depth_reg    <= '0;
            bracket_kinds_reg <= '0;
            quote_state_reg   <= '0;
            square_open_reg   <= 1'b0;
            char_index_reg    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg     <= 1'b1;
                nest_depth_reg    <= nest_depth_next;
                bracket_kinds_reg <= bracket_kinds_next;
                quote_state_reg   <= quote_state_next;
                square_open_reg   <= square_open_next;
                char_index_reg    <= char_index_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_data;
        if (advance)
            out_item_reg <= result;
    end

endmodule
